// ----- design/lsa_pkg.sv -----
// Shared definitions for the lowest-slot allocator: operation codes and the
// fixed field widths of the request and result ports.
// Depends on nothing; used by lowest_slot_allocator_fifo_wait.
package lsa_pkg;

    // Request operation codes.
    typedef enum logic [1:0] {
        OP_ARRIVAL   = 2'd0,
        OP_DEPARTURE = 2'd1,
        OP_LOAD      = 2'd2,
        OP_UNUSED    = 2'd3
    } op_t;

    // Field widths of the request and result ports.
    localparam int ID_W     = 6;
    localparam int WEIGHT_W = 14;
    localparam int SIDX_W   = 4;
    localparam int RATE_W   = 8;
    localparam int CHARGE_W = 22;
    localparam int TOTAL_W  = 32;
    localparam int CFG_W    = 5;

endpackage

// ----- design/lsa_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; instanced for every table of the slot allocator.
module lsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read, both on the rising edge.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- design/lowest_slot_allocator_fifo_wait.sv -----
// Lowest-free-slot allocator with a queue of waiting requesters; uses lsa_pkg and lsa_ram.
// A load, an unused code or an arrival that only queues or is dropped stays in ST_IDLE,
// a departure without a grant visits ST_DEP. A granting arrival runs ST_RATE, ST_SUM, a
// granting departure ST_DEP, ST_RATE, ST_SUM (holder read, rate read and multiply, total
// update); done is registered from ST_SUM. Requests are taken only in ST_IDLE. done lasts
// one cycle and cannot be stalled. Reset and cfg_we clear all holders in ST_CLEAR.
module lowest_slot_allocator_fifo_wait #(
    parameter int SLOT_COUNT      = 16,
    parameter int REQUESTER_COUNT = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   operation,
    input  logic [lsa_pkg::ID_W-1:0]     requester_id,
    input  logic [lsa_pkg::WEIGHT_W-1:0] weight,
    input  logic [lsa_pkg::SIDX_W-1:0]   slot_index,
    input  logic [lsa_pkg::RATE_W-1:0]   slot_rate,
    input  logic                         cfg_we,
    input  logic [lsa_pkg::CFG_W-1:0]    cfg_wdata,
    output logic                         done,
    output logic [lsa_pkg::ID_W-1:0]     assigned_id,
    output logic [lsa_pkg::SIDX_W-1:0]   assigned_slot,
    output logic [lsa_pkg::CHARGE_W-1:0] charge,
    output logic [lsa_pkg::TOTAL_W-1:0]  running_total
);

    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int RID_W       = $clog2(REQUESTER_COUNT);
    localparam int CNT_W       = $clog2(REQUESTER_COUNT + 1);
    localparam int HOLD_W      = SLOT_W + 1;
    localparam int FIFO_W      = lsa_pkg::ID_W + lsa_pkg::WEIGHT_W;
    localparam int RESET_SLOTS = (SLOT_COUNT < 16) ? SLOT_COUNT : 16;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DEP,
        ST_RATE,
        ST_SUM
    } state_t;

    // Free map with the low n bits set; callers pass n already clamped to 1..SLOT_COUNT.
    function automatic logic [SLOT_COUNT-1:0] initial_free(input int n);
        logic [SLOT_COUNT-1:0] map;
        map = '0;
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            map[s] = (s < n);
        end
        return map;
    endfunction

    // Queue pointer increment with wrap at the queue depth.
    function automatic logic [RID_W-1:0] ptr_inc(input logic [RID_W-1:0] p);
        return (p == RID_W'(REQUESTER_COUNT - 1)) ? '0 : p + 1'b1;
    endfunction

    state_t                          state_reg, state_next;
    logic [RID_W-1:0]                clr_cnt_reg, clr_cnt_next;
    logic [SLOT_COUNT-1:0]           free_map_reg, free_map_next;
    logic [SLOT_COUNT-1:0]           rate_valid_reg, rate_valid_next;
    logic [RID_W-1:0]                head_reg, head_next;
    logic [RID_W-1:0]                tail_reg, tail_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [lsa_pkg::TOTAL_W-1:0]     total_reg, total_next;
    logic                            done_reg, done_next;
    logic                            set_holder_reg, set_holder_next;

    logic [lsa_pkg::ID_W-1:0]        cur_id_reg, cur_id_next;
    logic [lsa_pkg::WEIGHT_W-1:0]    cur_weight_reg, cur_weight_next;
    logic [SLOT_W-1:0]               cur_slot_reg, cur_slot_next;
    logic [RID_W-1:0]                dep_rid_reg, dep_rid_next;
    logic [lsa_pkg::CHARGE_W-1:0]    product_reg, product_next;

    logic                            hold_wr_en;
    logic [RID_W-1:0]                hold_wr_addr;
    logic [HOLD_W-1:0]               hold_wr_data;
    logic [HOLD_W-1:0]               hold_rd_data;
    logic                            fifo_wr_en;
    logic [FIFO_W-1:0]               fifo_rd_data;
    logic                            rate_wr_en;
    logic [SLOT_W-1:0]               rate_rd_addr;
    logic [lsa_pkg::RATE_W-1:0]      rate_rd_data;

    logic [SLOT_COUNT-1:0]           free_iso;
    logic [SLOT_W-1:0]               low_slot;
    logic                            free_any;
    logic                            id_ok;
    logic                            slot_ok;
    int                              cfg_slots;
    logic [lsa_pkg::RATE_W-1:0]      rate_q;
    logic [lsa_pkg::TOTAL_W:0]       sum_wide;

    // Lowest free slot: isolate the lowest set bit, then encode it.
    always_comb
    begin
        free_iso = free_map_reg & ((~free_map_reg) + SLOT_COUNT'(1));
        low_slot = '0;
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            if (free_iso[s])
            begin
                low_slot = low_slot | SLOT_W'(s);
            end
        end
        free_any = |free_map_reg;
    end

    // Range checks on the request and clamping of the configuration value.
    always_comb
    begin
        id_ok   = int'(requester_id) < REQUESTER_COUNT;
        slot_ok = int'(slot_index) < SLOT_COUNT;
        if (cfg_wdata == '0)
        begin
            cfg_slots = 1;
        end
        else if (int'(cfg_wdata) > SLOT_COUNT)
        begin
            cfg_slots = SLOT_COUNT;
        end
        else
        begin
            cfg_slots = int'(cfg_wdata);
        end
    end

    assign rate_q   = rate_valid_reg[cur_slot_reg] ? rate_rd_data : '0;
    assign sum_wide = {1'b0, total_reg} + (lsa_pkg::TOTAL_W + 1)'(product_reg);

    // Sequencer: next state, table accesses and datapath updates.
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        free_map_next   = free_map_reg;
        rate_valid_next = rate_valid_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        done_next       = 1'b0;
        set_holder_next = set_holder_reg;
        cur_id_next     = cur_id_reg;
        cur_weight_next = cur_weight_reg;
        cur_slot_next   = cur_slot_reg;
        dep_rid_next    = dep_rid_reg;
        product_next    = product_reg;
        hold_wr_en      = 1'b0;
        hold_wr_addr    = RID_W'(requester_id);
        hold_wr_data    = '0;
        fifo_wr_en      = 1'b0;
        rate_wr_en      = 1'b0;
        rate_rd_addr    = cur_slot_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                hold_wr_en   = 1'b1;
                hold_wr_addr = clr_cnt_reg;
                if (clr_cnt_reg == RID_W'(REQUESTER_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        lsa_pkg::OP_LOAD:
                        begin
                            if (slot_ok)
                            begin
                                rate_wr_en = 1'b1;
                                rate_valid_next[SLOT_W'(slot_index)] = 1'b1;
                            end
                        end
                        lsa_pkg::OP_ARRIVAL:
                        begin
                            if (id_ok && (count_reg != CNT_W'(REQUESTER_COUNT)))
                            begin
                                if (free_any)
                                begin
                                    // A free slot means the queue is empty: the new
                                    // requester passes straight through it.
                                    cur_id_next             = requester_id;
                                    cur_weight_next         = weight;
                                    cur_slot_next           = low_slot;
                                    free_map_next[low_slot] = 1'b0;
                                    head_next               = ptr_inc(head_reg);
                                    tail_next               = ptr_inc(tail_reg);
                                    hold_wr_en              = 1'b1;
                                    hold_wr_data            = {1'b1, low_slot};
                                    rate_rd_addr            = low_slot;
                                    set_holder_next         = 1'b0;
                                    state_next              = ST_RATE;
                                end
                                else
                                begin
                                    fifo_wr_en = 1'b1;
                                    tail_next  = ptr_inc(tail_reg);
                                    count_next = count_reg + 1'b1;
                                end
                            end
                        end
                        lsa_pkg::OP_DEPARTURE:
                        begin
                            if (id_ok)
                            begin
                                dep_rid_next = RID_W'(requester_id);
                                state_next   = ST_DEP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DEP:
            begin
                if (!hold_rd_data[HOLD_W-1])
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    hold_wr_en   = 1'b1;
                    hold_wr_addr = dep_rid_reg;
                    if (count_reg == '0)
                    begin
                        free_map_next[hold_rd_data[SLOT_W-1:0]] = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // Waiters mean no other slot is free: the freed slot goes to
                        // the oldest waiter.
                        cur_id_next     = fifo_rd_data[FIFO_W-1 -: lsa_pkg::ID_W];
                        cur_weight_next = fifo_rd_data[lsa_pkg::WEIGHT_W-1:0];
                        cur_slot_next   = hold_rd_data[SLOT_W-1:0];
                        head_next       = ptr_inc(head_reg);
                        count_next      = count_reg - 1'b1;
                        rate_rd_addr    = hold_rd_data[SLOT_W-1:0];
                        set_holder_next = 1'b1;
                        state_next      = ST_RATE;
                    end
                end
            end
            ST_RATE:
            begin
                product_next = lsa_pkg::CHARGE_W'(cur_weight_reg)
                             * lsa_pkg::CHARGE_W'(rate_q);
                if (set_holder_reg)
                begin
                    hold_wr_en   = 1'b1;
                    hold_wr_addr = RID_W'(cur_id_reg);
                    hold_wr_data = {1'b1, cur_slot_reg};
                end
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                total_next = sum_wide[lsa_pkg::TOTAL_W] ? '1 : sum_wide[lsa_pkg::TOTAL_W-1:0];
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A configuration write restarts the allocation and the clearing pass.
        if (cfg_we)
        begin
            state_next    = ST_CLEAR;
            clr_cnt_next  = '0;
            free_map_next = initial_free(cfg_slots);
            head_next     = '0;
            tail_next     = '0;
            count_next    = '0;
        end
    end

    // Control state, the request in flight and the registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            free_map_reg   <= initial_free(RESET_SLOTS);
            rate_valid_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            total_reg      <= '0;
            done_reg       <= 1'b0;
            set_holder_reg <= 1'b0;
            cur_id_reg     <= '0;
            cur_weight_reg <= '0;
            cur_slot_reg   <= '0;
            dep_rid_reg    <= '0;
            product_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            free_map_reg   <= free_map_next;
            rate_valid_reg <= rate_valid_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            done_reg       <= done_next;
            set_holder_reg <= set_holder_next;
            cur_id_reg     <= cur_id_next;
            cur_weight_reg <= cur_weight_next;
            cur_slot_reg   <= cur_slot_next;
            dep_rid_reg    <= dep_rid_next;
            product_reg    <= product_next;
        end
    end

    // Slot held by each requester, with its valid bit on top.
    lsa_ram #(
        .WIDTH(HOLD_W),
        .DEPTH(REQUESTER_COUNT)
    ) u_holder (
        .clk    (clk),
        .wr_en  (hold_wr_en),
        .wr_addr(hold_wr_addr),
        .wr_data(hold_wr_data),
        .rd_addr(RID_W'(requester_id)),
        .rd_data(hold_rd_data)
    );

    // Queue of waiting requesters: id and weight.
    lsa_ram #(
        .WIDTH(FIFO_W),
        .DEPTH(REQUESTER_COUNT)
    ) u_wait_fifo (
        .clk    (clk),
        .wr_en  (fifo_wr_en),
        .wr_addr(tail_reg),
        .wr_data({requester_id, weight}),
        .rd_addr(head_reg),
        .rd_data(fifo_rd_data)
    );

    // Charge rate of each slot.
    lsa_ram #(
        .WIDTH(lsa_pkg::RATE_W),
        .DEPTH(SLOT_COUNT)
    ) u_rate (
        .clk    (clk),
        .wr_en  (rate_wr_en),
        .wr_addr(SLOT_W'(slot_index)),
        .wr_data(slot_rate),
        .rd_addr(rate_rd_addr),
        .rd_data(rate_rd_data)
    );

    // Outputs hold until the next request is accepted, so they serve as the result.
    assign busy          = (state_reg != ST_IDLE);
    assign done          = done_reg;
    assign assigned_id   = cur_id_reg;
    assign assigned_slot = lsa_pkg::SIDX_W'(cur_slot_reg);
    assign charge        = product_reg;
    assign running_total = total_reg;

    // A result only ever follows the total update.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_SUM))
        else $error("result strobe without a total update");

    // A result strobe lasts one cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");

    // The queue never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(REQUESTER_COUNT))
        else $error("wait queue overfilled");

    // Between requests a free slot and a waiter never coexist.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((count_reg == '0) || (free_map_reg == '0)))
        else $error("free slot left while requesters wait");

endmodule
